>>> sv/pols_pkg.sv
// shared constants and the quarter-wave cosine table of the oscillator step core
`timescale 1ns / 1ps
package pols_pkg;

  localparam int unsigned COS_TABLE_ENTRIES = 1024;
  localparam int unsigned COS_IDX_W = $clog2(COS_TABLE_ENTRIES);
  localparam int unsigned QTR_W = COS_IDX_W - 2;
  localparam int unsigned QTR_ENTRIES = COS_TABLE_ENTRIES / 4;

  localparam logic signed [63:0] ESCAPE_LIMIT = 64'sd72057594037927936;

  localparam longint Q30_ONE = 64'sd1073741824;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  typedef logic [14:0] cos_mag_t;
  typedef cos_mag_t cos_tbl_t [QTR_ENTRIES+1];

  // taylor cosine of one quarter-wave point, rounded to q1.14 magnitude
  function automatic cos_mag_t cos_entry(int unsigned k);
    longint unsigned u;
    longint unsigned xu;
    longint x2;
    longint p;
    u  = longint'(k) << (30 - QTR_W);
    xu = (u * HALF_PI_Q30) >> 30;
    x2 = longint'((xu * xu) >> 30);
    p  = Q30_ONE;
    p  = Q30_ONE - (x2 * p) / (90 * Q30_ONE);
    p  = Q30_ONE - (x2 * p) / (56 * Q30_ONE);
    p  = Q30_ONE - (x2 * p) / (30 * Q30_ONE);
    p  = Q30_ONE - (x2 * p) / (12 * Q30_ONE);
    p  = Q30_ONE - (x2 * p) / (2 * Q30_ONE);
    if (p < 0) begin
      p = 0;
    end
    if (p > Q30_ONE) begin
      p = Q30_ONE;
    end
    p = (p + 32768) >>> 16;
    return cos_mag_t'(p);
  endfunction

  function automatic cos_tbl_t build_cos_tbl();
    cos_tbl_t t;
    for (int unsigned k = 0; k <= QTR_ENTRIES; k++) begin
      t[k] = cos_entry(k);
    end
    return t;
  endfunction

  localparam cos_tbl_t COS_TBL = build_cos_tbl();

endpackage

>>> sv/pols_if.sv
// request and result channel interfaces of the oscillator step core
`timescale 1ns / 1ps
interface pols_req_if;
  logic               valid;
  logic               ready;
  logic               action;
  logic signed [63:0] start_position;
  logic signed [15:0] noise_sample;
  modport source(output valid, action, start_position, noise_sample, input ready);
  modport sink(input valid, action, start_position, noise_sample, output ready);
endinterface

interface pols_res_if;
  logic               valid;
  logic               ready;
  logic        [31:0] step_index;
  logic signed [63:0] position;
  logic signed [63:0] velocity_per_step;
  logic               lost;
  modport source(output valid, step_index, position, velocity_per_step, lost, input ready);
  modport sink(input valid, step_index, position, velocity_per_step, lost, output ready);
endinterface

>>> sv/parametric_oscillator_langevin_step_core.sv
// langevin step core of a parametrically driven damped oscillator
//
//   channel   dir   handshake              carries
//   req_i     in    valid/ready            action, start_position, noise_sample
//   res_o     out   valid/ready            step_index, position, velocity_per_step, lost
//   apb       in    psel/penable/pwrite    seven registers at 8*i, 64-bit data
//
// a step request runs the cosine lookup, factor, products, kicks and position update;
// the next request is taken back in idle, after the emit state when the step emits
// six 64x64 products run through one shared 32x32 multiplier, four partials each
// a restart passes through the emit state back to idle; a step after escape is absorbed in idle
// reset clears the integrator state, the output valid and the registers (save_interval to 1); no clearing pass
// a result waits in the output register; the core parks until that slot is free
`timescale 1ns / 1ps
module parametric_oscillator_langevin_step_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  pols_req_if.sink    req_i,
  pols_res_if.source  res_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import pols_pkg::*;

  typedef enum logic [2:0] {
    REG_HALF_SPRING, REG_HALF_DAMP, REG_NOISE_GAIN, REG_MOD_DEPTH,
    REG_PHASE_STEP, REG_PHASE_OFFSET, REG_SAVE_INTERVAL
  } reg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_COS, ST_FACT, ST_MLOAD, ST_MRUN, ST_MFIN,
    ST_KA, ST_KB, ST_VEL, ST_POS, ST_DONE, ST_EMIT
  } state_e;

  typedef enum logic [1:0] {OP_K, OP_NT, OP_S, OP_DM} mul_op_e;

  localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] S64_MIN = {1'b1, {63{1'b0}}};
  localparam logic signed [31:0] FACTOR_ONE = 32'sd268435456;

  // saturating add on the signed 64-bit range
  function automatic logic signed [63:0] sat_add(logic signed [63:0] a, logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      return s[64] ? S64_MIN : S64_MAX;
    end
    return s[63:0];
  endfunction

  // negation, most negative value maps to the maximum
  function automatic logic signed [63:0] neg_sat(logic signed [63:0] a);
    return (a == S64_MIN) ? S64_MAX : -a;
  endfunction

  function automatic logic [63:0] mag64(logic signed [63:0] a);
    return a[63] ? (64'd0 - a) : a;
  endfunction

  // configuration registers
  logic        [47:0] hsc_q, hdc_q, ngain_q;
  logic signed [15:0] depth_q;
  logic        [31:0] pstep_q, poff_q;
  logic        [15:0] sint_q;

  // integrator state
  state_e             state_q;
  logic signed [63:0] pos_q, vel_q;
  logic        [31:0] phase_q, stepc_q;
  logic        [15:0] savec_q;
  logic               lost_q;

  // working registers of one step
  logic signed [15:0] noise_q;
  cos_mag_t           cmag_q;
  logic               cneg_q;
  logic signed [31:0] factor_q;
  logic signed [63:0] k_q, nt_q, s_q, dm_q, t_q, d_q;
  mul_op_e            op_q;
  logic               pass2_q;

  // shared multiplier
  logic [63:0]  ma_q, mb_q;
  logic         mneg_q;
  logic [1:0]   mcnt_q;
  logic [127:0] acc_q;

  // result register
  logic               ovalid_q;
  logic        [31:0] ostep_q;
  logic signed [63:0] opos_q, ovel_q;
  logic               olost_q;
  logic        [31:0] rstep_q;
  logic signed [63:0] rpos_q, rvel_q;
  logic               rlost_q;

  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    unique case (paddr[5:3])
      REG_HALF_SPRING:   prdata = {16'd0, hsc_q};
      REG_HALF_DAMP:     prdata = {16'd0, hdc_q};
      REG_NOISE_GAIN:    prdata = {16'd0, ngain_q};
      REG_MOD_DEPTH:     prdata = {48'd0, depth_q};
      REG_PHASE_STEP:    prdata = {32'd0, pstep_q};
      REG_PHASE_OFFSET:  prdata = {32'd0, poff_q};
      REG_SAVE_INTERVAL: prdata = {48'd0, sint_q};
      default:           prdata = 64'd0;
    endcase
  end

  assign req_i.ready          = (state_q == ST_IDLE);
  assign res_o.valid          = ovalid_q;
  assign res_o.step_index     = ostep_q;
  assign res_o.position       = opos_q;
  assign res_o.velocity_per_step = ovel_q;
  assign res_o.lost           = olost_q;

  // the parked result moves into the output slot when it is free or being taken
  logic emit_go;
  assign emit_go = (state_q == ST_EMIT) && (!ovalid_q || res_o.ready);

  // cosine table address from the quantized phase, folded to a quarter wave
  logic [COS_IDX_W-1:0] cidx;
  logic [1:0]           cquad;
  logic [QTR_W:0]       carg;
  assign cidx  = phase_q[31 -: COS_IDX_W];
  assign cquad = cidx[COS_IDX_W-1 -: 2];
  assign carg  = cquad[0] ? ((QTR_W+1)'(QTR_ENTRIES) - {1'b0, cidx[QTR_W-1:0]})
                          : {1'b0, cidx[QTR_W-1:0]};

  logic signed [15:0] cos_s;
  logic signed [31:0] depth_prod;
  assign cos_s      = cneg_q ? -$signed({1'b0, cmag_q}) : $signed({1'b0, cmag_q});
  assign depth_prod = depth_q * cos_s;

  // multiplier operand selection
  logic signed [63:0] op_a, op_b;
  always_comb begin
    unique case (op_q)
      OP_K:  begin op_a = {16'd0, hsc_q};   op_b = 64'(factor_q); end
      OP_NT: begin op_a = {16'd0, ngain_q}; op_b = 64'(noise_q);  end
      OP_S:  begin op_a = k_q;              op_b = pos_q;         end
      OP_DM: begin op_a = {16'd0, hdc_q};   op_b = vel_q;         end
    endcase
  end

  // one 32x32 partial product per cycle in the run state, low/high halves picked by the count
  logic [31:0]  pa, pb;
  logic [63:0]  pprod;
  logic [127:0] pacc;
  assign pa    = mcnt_q[1] ? ma_q[63:32] : ma_q[31:0];
  assign pb    = mcnt_q[0] ? mb_q[63:32] : mb_q[31:0];
  assign pprod = pa * pb;
  always_comb begin
    unique case (mcnt_q)
      2'd0:    pacc = {64'd0, pprod};
      2'd3:    pacc = {pprod, 64'd0};
      default: pacc = {32'd0, pprod, 32'd0};
    endcase
  end

  // truncate toward zero, then saturate
  logic [127:0]       mshift;
  logic signed [63:0] mres;
  logic               movf;
  always_comb begin
    unique case (op_q)
      OP_K:    mshift = acc_q >> 28;
      OP_NT:   mshift = acc_q >> 4;
      default: mshift = acc_q >> 48;
    endcase
    movf = (mshift[127:64] != 64'd0) || mshift[63];
    if (mneg_q) begin
      mres = movf ? S64_MIN : -$signed(mshift[63:0]);
    end else begin
      mres = movf ? S64_MAX : $signed(mshift[63:0]);
    end
  end

  logic [31:0] stepc_n;
  logic [15:0] savec_n;
  logic        esc;
  assign stepc_n = stepc_q + 32'd1;
  assign savec_n = savec_q + 16'd1;
  assign esc     = (pos_q > ESCAPE_LIMIT) || (pos_q < -ESCAPE_LIMIT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hsc_q    <= '0;
      hdc_q    <= '0;
      ngain_q  <= '0;
      depth_q  <= '0;
      pstep_q  <= '0;
      poff_q   <= '0;
      sint_q   <= 16'd1;
      state_q  <= ST_IDLE;
      pos_q    <= '0;
      vel_q    <= '0;
      phase_q  <= '0;
      stepc_q  <= '0;
      savec_q  <= '0;
      lost_q   <= 1'b0;
      ovalid_q <= 1'b0;
      pass2_q  <= 1'b0;
      op_q     <= OP_K;
      mcnt_q   <= '0;
    end else begin
      if (cfg_wr) begin
        unique case (paddr[5:3])
          REG_HALF_SPRING:   hsc_q   <= pwdata[47:0];
          REG_HALF_DAMP:     hdc_q   <= pwdata[47:0];
          REG_NOISE_GAIN:    ngain_q <= pwdata[47:0];
          REG_MOD_DEPTH:     depth_q <= pwdata[15:0];
          REG_PHASE_STEP:    pstep_q <= pwdata[31:0];
          REG_PHASE_OFFSET:  poff_q  <= pwdata[31:0];
          REG_SAVE_INTERVAL: sint_q  <= pwdata[15:0];
          default: ;
        endcase
      end

      if (emit_go) begin
        ovalid_q <= 1'b1;
      end else if (ovalid_q && res_o.ready) begin
        ovalid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (req_i.valid) begin
            if (!req_i.action) begin
              // restart: load position, emit step zero
              pos_q   <= req_i.start_position;
              vel_q   <= '0;
              stepc_q <= '0;
              savec_q <= '0;
              lost_q  <= 1'b0;
              phase_q <= poff_q;
              rstep_q <= '0;
              rpos_q  <= req_i.start_position;
              rvel_q  <= '0;
              rlost_q <= 1'b0;
              state_q <= ST_EMIT;
            end else if (!lost_q) begin
              noise_q <= req_i.noise_sample;
              pass2_q <= 1'b0;
              state_q <= ST_COS;
            end
          end
        end
        ST_COS: begin
          cmag_q  <= COS_TBL[carg];
          cneg_q  <= cquad[1] ^ cquad[0];
          state_q <= ST_FACT;
        end
        ST_FACT: begin
          factor_q <= FACTOR_ONE + depth_prod;
          op_q     <= OP_K;
          state_q  <= ST_MLOAD;
        end
        ST_MLOAD: begin
          ma_q    <= mag64(op_a);
          mb_q    <= mag64(op_b);
          mneg_q  <= op_a[63] ^ op_b[63];
          acc_q   <= '0;
          mcnt_q  <= '0;
          state_q <= ST_MRUN;
        end
        ST_MRUN: begin
          acc_q  <= acc_q + pacc;
          mcnt_q <= mcnt_q + 2'd1;
          if (mcnt_q == 2'd3) begin
            state_q <= ST_MFIN;
          end
        end
        ST_MFIN: begin
          unique case (op_q)
            OP_K:  begin k_q  <= mres; op_q <= OP_NT; state_q <= ST_MLOAD; end
            OP_NT: begin nt_q <= mres; op_q <= OP_S;  state_q <= ST_MLOAD; end
            OP_S:  begin s_q  <= mres; op_q <= OP_DM; state_q <= ST_MLOAD; end
            OP_DM: begin dm_q <= mres; state_q <= ST_KA; end
          endcase
        end
        // kick = noise - spring - damping, then the half-kick on velocity
        ST_KA: begin
          t_q     <= sat_add(nt_q, neg_sat(s_q));
          state_q <= ST_KB;
        end
        ST_KB: begin
          d_q     <= sat_add(t_q, neg_sat(dm_q));
          state_q <= ST_VEL;
        end
        ST_VEL: begin
          vel_q   <= sat_add(vel_q, d_q);
          state_q <= pass2_q ? ST_DONE : ST_POS;
        end
        ST_POS: begin
          pos_q   <= sat_add(pos_q, vel_q);
          pass2_q <= 1'b1;
          op_q    <= OP_S;
          state_q <= ST_MLOAD;
        end
        ST_DONE: begin
          stepc_q <= stepc_n;
          phase_q <= phase_q + pstep_q;
          rstep_q <= stepc_n;
          rpos_q  <= pos_q;
          rvel_q  <= vel_q;
          rlost_q <= esc;
          if (esc) begin
            lost_q  <= 1'b1;
            savec_q <= savec_n;
            state_q <= ST_EMIT;
          end else if (savec_n >= sint_q) begin
            savec_q <= '0;
            state_q <= ST_EMIT;
          end else begin
            savec_q <= savec_n;
            state_q <= ST_IDLE;
          end
        end
        ST_EMIT: begin
          // wait for the output slot, then hand the result over
          if (emit_go) begin
            ostep_q  <= rstep_q;
            opos_q   <= rpos_q;
            ovel_q   <= rvel_q;
            olost_q  <= rlost_q;
            state_q  <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> sv/pols_checker.sv
// port-level checks of the oscillator step core and their bind
`timescale 1ns / 1ps
module pols_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               req_valid_i,
  input logic               req_ready_i,
  input logic               req_action_i,
  input logic               res_valid_i,
  input logic               res_ready_i,
  input logic        [31:0] res_step_i,
  input logic signed [63:0] res_position_i,
  input logic               res_lost_i
);
  import pols_pkg::*;

  // a stalled result holds
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_step_i)
      && $stable(res_position_i) && $stable(res_lost_i))
    else $error("stalled result changed");

  // a restart takes the core out of idle to emit its result
  a_restart_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i && !req_action_i |=> !req_ready_i)
    else $error("ready right after restart");

  // a lost result carries an escaped position
  a_lost_escape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_lost_i |-> (res_position_i > ESCAPE_LIMIT)
      || (res_position_i < -ESCAPE_LIMIT))
    else $error("lost result inside limit");

  // no result during reset
  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |-> !res_valid_i)
    else $error("result valid in reset");

endmodule

bind parametric_oscillator_langevin_step_core pols_checker u_pols_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .req_valid_i    (req_i.valid),
  .req_ready_i    (req_i.ready),
  .req_action_i   (req_i.action),
  .res_valid_i    (res_o.valid),
  .res_ready_i    (res_o.ready),
  .res_step_i     (res_o.step_index),
  .res_position_i (res_o.position),
  .res_lost_i     (res_o.lost)
);
